@@ sv/vmcp_pkg.sv @@
// Shared constants and types for the video memory CPU port.
// No dependencies; imported by vmcp_clear, the core and the bench.
package vmcp_pkg;

   localparam int ADDR_BITS = 14;
   localparam int RAM_DEPTH = 1 << ADDR_BITS;
   localparam int NUM_REGS  = 8;
   localparam int LOW_BITS  = 6;

   // access kinds carried on req_tuser
   localparam logic [1:0] MODE_READ  = 2'd0;
   localparam logic [1:0] MODE_WRITE = 2'd1;
   localparam logic [1:0] MODE_CMD   = 2'd2;

   // second command byte, bits 7..6
   localparam logic [1:0] CMD_SET_READ  = 2'd0;
   localparam logic [1:0] CMD_SET_WRITE = 2'd1;
   localparam logic [1:0] CMD_REG_WRITE = 2'd2;

   localparam int RSP_BITS = 24;

   typedef logic [ADDR_BITS-1:0] addr_type;

   typedef struct packed {
      logic     busy;
      addr_type addr;
   } clear_status_type;

endpackage

@@ sv/vmcp_ram.sv @@
// Generic single-clock RAM, one write and one read port, registered read.
// No dependencies.
module vmcp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

@@ sv/vmcp_clear.sv @@
// Post-reset sweep that zeroes the video RAM one byte per cycle.
// Depends on vmcp_pkg.
module vmcp_clear import vmcp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   output clear_status_type status
);

   logic     busy_ff, busy_in;
   addr_type cnt_ff, cnt_in;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (busy_ff) begin
         cnt_in = cnt_ff + addr_type'(1);
         if (cnt_ff == {ADDR_BITS{1'b1}}) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.addr = cnt_ff;

endmodule

@@ sv/video_memory_cpu_port_core.sv @@
// Video memory CPU port: one bus access per request, one response each.
// Each response is registered; throughput one request per cycle, held back
// by rsp_tready and by the RAM clear. The read-ahead byte comes from
// the RAM's registered read port and is bypassed into the next request.
// Reset is synchronous; afterwards all 2^ADDR_BITS (16384) RAM bytes are
// zeroed, and req_tready stays low meanwhile.
module video_memory_cpu_port_core import vmcp_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,   // [7:0] write_byte
   input  logic [1:0]          req_tuser,   // [1:0] mode
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // [7:0] read_byte, [8] reg_write_valid, [11:9] reg_index,
   // [19:12] reg_value, [20] command_error, [23:21] zero
   output logic [RSP_BITS-1:0] rsp_tdata
);

   clear_status_type clr;

   addr_type   addr_ff, addr_in;
   logic [7:0] latch_ff, latch_in;
   logic       pend_ff, pend_in;     // latch value sits in ram_rdata
   logic [7:0] first_ff, first_in;
   logic       expect_ff, expect_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [RSP_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic       accept;
   logic [7:0] cur_latch;
   logic [7:0] ram_rdata;
   logic       ram_rd_en, ram_wr_en;
   addr_type   ram_rd_addr, ram_wr_addr;
   logic [7:0] ram_wr_data;
   logic       acc_wr;

   logic [1:0]          code;
   logic [LOW_BITS-1:0] low;
   logic [13:0]         cmd_addr_full;
   addr_type            cmd_addr;
   logic [7:0]          o_rd, o_val;
   logic                o_valid, o_err;
   logic [2:0]          o_idx;

   vmcp_clear u_clear (
      .clock  (clock),
      .reset  (reset),
      .status (clr)
   );

   vmcp_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rdata)
   );

   assign req_tready = !clr.busy && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign cur_latch  = pend_ff ? ram_rdata : latch_ff;

   assign code          = req_tdata[7:6];
   assign low           = req_tdata[LOW_BITS-1:0];
   assign cmd_addr_full = {low, first_ff};
   assign cmd_addr      = cmd_addr_full[ADDR_BITS-1:0];

   assign ram_wr_en   = clr.busy || acc_wr;
   assign ram_wr_addr = clr.busy ? clr.addr : addr_ff;
   assign ram_wr_data = clr.busy ? 8'd0 : req_tdata;

   always_comb begin
      addr_in     = addr_ff;
      latch_in    = cur_latch;
      pend_in     = 1'b0;
      first_in    = first_ff;
      expect_in   = expect_ff;
      ram_rd_en   = 1'b0;
      ram_rd_addr = addr_ff;
      acc_wr      = 1'b0;
      o_rd        = 8'd0;
      o_valid     = 1'b0;
      o_idx       = 3'd0;
      o_val       = 8'd0;
      o_err       = 1'b0;
      if (accept) begin
         case (req_tuser)
            MODE_READ: begin
               expect_in = 1'b0;
               o_rd      = cur_latch;
               ram_rd_en = 1'b1;
               pend_in   = 1'b1;
               addr_in   = addr_ff + addr_type'(1);
            end
            MODE_WRITE: begin
               expect_in = 1'b0;
               acc_wr    = 1'b1;
               latch_in  = req_tdata;  // prefetch would read back this byte
               addr_in   = addr_ff + addr_type'(1);
            end
            MODE_CMD: begin
               if (!expect_ff) begin
                  first_in  = req_tdata;
                  expect_in = 1'b1;
               end else begin
                  expect_in = 1'b0;
                  case (code)
                     CMD_SET_READ: begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = cmd_addr;
                        pend_in     = 1'b1;
                        addr_in     = cmd_addr + addr_type'(1);
                     end
                     CMD_SET_WRITE: begin
                        addr_in = cmd_addr;
                     end
                     CMD_REG_WRITE: begin
                        if (low < LOW_BITS'(NUM_REGS)) begin
                           o_valid = 1'b1;
                           o_idx   = low[2:0];
                           o_val   = first_ff;
                        end else begin
                           o_err = 1'b1;
                        end
                     end
                     default: begin
                        o_err = 1'b1;
                     end
                  endcase
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {3'd0, o_err, o_val, o_idx, o_valid, o_rd};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff      <= '0;
         latch_ff     <= 8'd0;
         pend_ff      <= 1'b0;
         first_ff     <= 8'd0;
         expect_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         addr_ff      <= addr_in;
         latch_ff     <= latch_in;
         pend_ff      <= pend_in;
         first_ff     <= first_in;
         expect_ff    <= expect_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ tb/video_memory_cpu_port_core_tb.sv @@
// Self-checking bench for video_memory_cpu_port_core: bus accesses in, one result each out.
// A scoreboard class tracks the VRAM, address, read-ahead latch and command state.
// Depends on vmcp_pkg and the core RTL.
`timescale 1ns / 100ps

module video_memory_cpu_port_core_tb;
   import vmcp_pkg::*;

   localparam logic [1:0] MODE_UNUSED   = 2'd3;
   localparam logic [1:0] CMD_UNDEFINED = 2'd3;
   localparam int TOTAL_ACCESSES = 760;
   localparam int STALL_LIMIT    = 50000;  // covers the 16K-byte RAM clear after reset
   localparam int HOLD_CYCLES    = 300;
   localparam int MAX_MESSAGES   = 40;

   typedef struct packed {
      logic [2:0] pad;
      logic       command_error;
      logic [7:0] reg_value;
      logic [2:0] reg_index;
      logic       reg_write_valid;
      logic [7:0] read_byte;
   } bus_result_type;

   class bus_port_scoreboard;
      logic [7:0]     vram [RAM_DEPTH];
      logic [7:0]     ctrl_regs [NUM_REGS];
      addr_type       access_addr;
      logic [7:0]     read_latch;
      logic [7:0]     cmd_first;
      logic           second_pending;
      bus_result_type pending_results [$];
      int             failures;
      int             checked;

      function new();
         foreach (vram[i]) vram[i] = '0;
         foreach (ctrl_regs[i]) ctrl_regs[i] = '0;
         access_addr    = '0;
         read_latch     = '0;
         cmd_first      = '0;
         second_pending = 1'b0;
         failures       = 0;
         checked        = 0;
      endfunction

      function void prefetch();
         read_latch  = vram[access_addr];
         access_addr = access_addr + addr_type'(1);
      endfunction

      // predict the result of one accepted request and queue it
      function void note_access(logic [1:0] mode, logic [7:0] value);
         bus_result_type r;
         logic [1:0]     code;
         logic [5:0]     low;
         addr_type       target;
         r    = '0;
         code = value[7:6];
         low  = value[5:0];
         case (mode)
            MODE_READ: begin
               second_pending = 1'b0;
               r.read_byte = read_latch;
               prefetch();
            end
            MODE_WRITE: begin
               second_pending = 1'b0;
               vram[access_addr] = value;
               prefetch();
            end
            MODE_CMD: begin
               if (!second_pending) begin
                  cmd_first      = value;
                  second_pending = 1'b1;
               end else begin
                  target = addr_type'({low, cmd_first});
                  case (code)
                     CMD_SET_READ: begin
                        access_addr = target;
                        prefetch();
                     end
                     CMD_SET_WRITE: access_addr = target;
                     CMD_REG_WRITE: begin
                        if (low < NUM_REGS) begin
                           ctrl_regs[low[2:0]] = cmd_first;
                           r.reg_write_valid   = 1'b1;
                           r.reg_index         = low[2:0];
                           r.reg_value         = cmd_first;
                        end else begin
                           r.command_error = 1'b1;
                        end
                     end
                     default: r.command_error = 1'b1;
                  endcase
                  second_pending = 1'b0;
               end
            end
            default: ;
         endcase
         pending_results.push_back(r);
      endfunction

      task report(string what, int got, int want);
         failures++;
         if (failures <= MAX_MESSAGES)
            $display("mismatch on result %0d: %s got 0x%0h expected 0x%0h",
                     checked, what, got, want);
      endtask

      task check_result(logic [RSP_BITS-1:0] data);
         bus_result_type got;
         bus_result_type want;
         got = data;
         if (pending_results.size() == 0) begin
            report("unexpected result, tdata", data, 0);
         end else begin
            want = pending_results.pop_front();
            if (got.read_byte !== want.read_byte)
               report("read_byte", got.read_byte, want.read_byte);
            if (got.reg_write_valid !== want.reg_write_valid)
               report("reg_write_valid", got.reg_write_valid, want.reg_write_valid);
            if (got.reg_index !== want.reg_index)
               report("reg_index", got.reg_index, want.reg_index);
            if (got.reg_value !== want.reg_value)
               report("reg_value", got.reg_value, want.reg_value);
            if (got.command_error !== want.command_error)
               report("command_error", got.command_error, want.command_error);
            if (got.pad !== want.pad)
               report("tdata[23:21]", got.pad, want.pad);
         end
         checked++;
      endtask
   endclass

   logic                clock = 1'b0;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [7:0]          req_tdata;   // [7:0] write_byte
   logic [1:0]          req_tuser;   // [1:0] mode
   logic                rsp_tvalid;
   logic                rsp_tready;
   // [7:0] read_byte, [8] reg_write_valid, [11:9] reg_index,
   // [19:12] reg_value, [20] command_error, [23:21] zero
   logic [RSP_BITS-1:0] rsp_tdata;

   bus_port_scoreboard sb = new();
   logic idle_enabled   = 1'b1;
   logic hold_requested = 1'b0;
   int   hold_left      = 0;
   int   stall_cycles   = 0;
   int   sent_count     = 0;

   video_memory_cpu_port_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // receiver: random back-pressure, plus one long hold-off on request
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left = hold_left - 1;
      end else if (hold_requested) begin
         rsp_tready <= 1'b0;
         hold_requested = 1'b0;
         hold_left = HOLD_CYCLES - 1;
      end else begin
         rsp_tready <= !(idle_enabled && $urandom_range(99) < 38);
      end
   end

   // result checking and watchdog
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata);
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task send_access(input logic [1:0] mode, input logic [7:0] value);
      while (idle_enabled && $urandom_range(99) < 38) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      sb.note_access(mode, value);
      sent_count++;
   endtask

   task send_command(input logic [7:0] first, input logic [1:0] code, input logic [5:0] low);
      send_access(MODE_CMD, first);
      send_access(MODE_CMD, {code, low});
   endtask

   task wait_drained();
      while (sb.pending_results.size() != 0)
         @(posedge clock);
   endtask

   // mostly well-formed command/data sequences, some noise and broken commands
   task random_sequence();
      addr_type   target;
      int         burst;
      int         pick;
      logic [1:0] code;
      pick  = $urandom_range(99);
      burst = $urandom_range(1, 8);
      case ($urandom_range(3))
         0:       target = addr_type'($urandom_range(63));
         1:       target = addr_type'(RAM_DEPTH - 1 - $urandom_range(31));
         default: target = addr_type'($urandom);
      endcase
      if (pick < 30) begin
         send_command(target[7:0], CMD_SET_WRITE, target[13:8]);
         repeat (burst) send_access(MODE_WRITE, 8'($urandom));
      end else if (pick < 60) begin
         send_command(target[7:0], CMD_SET_READ, target[13:8]);
         repeat (burst) send_access(MODE_READ, 8'($urandom));
      end else if (pick < 75) begin
         // register write, occasionally with an index past the register file
         if ($urandom_range(3) == 0)
            send_command(8'($urandom), CMD_REG_WRITE, 6'($urandom));
         else
            send_command(8'($urandom), CMD_REG_WRITE, 6'($urandom_range(NUM_REGS - 1)));
      end else if (pick < 85) begin
         send_access($urandom_range(1) ? MODE_READ : MODE_WRITE, 8'($urandom));
      end else if (pick < 92) begin
         // half a command cut short by a data access
         send_access(MODE_CMD, 8'($urandom));
         send_access($urandom_range(1) ? MODE_READ : MODE_WRITE, 8'($urandom));
      end else begin
         code = 2'($urandom);
         send_access(2'($urandom), 8'($urandom));
         send_access(MODE_CMD, {code, 6'($urandom)});
      end
   endtask

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= MODE_READ;
      rsp_tready <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, every command, wrap, dropped and undefined commands
      send_access(MODE_READ, 8'h00);
      send_access(MODE_WRITE, 8'hFF);
      send_access(MODE_WRITE, 8'h00);
      send_access(MODE_WRITE, 8'hA5);
      send_command(8'h01, CMD_SET_READ, 6'h00);
      send_access(MODE_READ, 8'hFF);
      send_access(MODE_READ, 8'h00);
      send_command(8'hFF, CMD_SET_WRITE, 6'h3F);
      send_access(MODE_WRITE, 8'h5A);   // last byte, address wraps to zero
      send_access(MODE_READ, 8'hFF);
      send_command(8'hFF, CMD_REG_WRITE, 6'd7);
      send_command(8'h81, CMD_REG_WRITE, 6'd0);
      send_command(8'h12, CMD_REG_WRITE, 6'd8);
      send_command(8'h34, CMD_REG_WRITE, 6'h3F);
      send_command(8'h56, CMD_UNDEFINED, 6'h3F);
      send_access(MODE_CMD, 8'h11);
      send_access(MODE_WRITE, 8'h77);   // drops the pending first byte
      send_access(MODE_CMD, 8'hFF);
      send_access(MODE_UNUSED, 8'hFF);  // leaves the pending first byte alone
      send_access(MODE_CMD, {CMD_SET_READ, 6'h3F});
      send_access(MODE_READ, 8'h00);

      while (sent_count < 250) random_sequence();
      // no idling; long receiver hold-off fills the block
      idle_enabled   = 1'b0;
      hold_requested = 1'b1;
      while (sent_count < 450) random_sequence();
      idle_enabled = 1'b1;
      req_tvalid <= 1'b0;
      wait_drained();
      while (sent_count < TOTAL_ACCESSES) random_sequence();

      req_tvalid <= 1'b0;
      wait_drained();
      repeat (10) @(posedge clock);
      if (sb.failures == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

@@ files.f @@
sv/vmcp_pkg.sv
sv/vmcp_ram.sv
sv/vmcp_clear.sv
sv/video_memory_cpu_port_core.sv
tb/video_memory_cpu_port_core_tb.sv
